// ===== rtl/shhd_pkg.sv =====
// Shared types and constants for the half-step stepper sequencer with homing.
`default_nettype none
package shhd_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_STEPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_STEPS   = 3'd4;

    localparam logic [15:0] RST_STEP_DELAY    = 16'd1;
    localparam logic [31:0] RST_PHASE_TABLE   = 32'h98C4_6231;
    localparam logic [15:0] RST_BACKOFF_STEPS = 16'd1000;
    localparam logic [15:0] RST_SEARCH_LIMIT  = 16'd5000;
    localparam logic [15:0] RST_FINAL_STEPS   = 16'd200;

    localparam logic [15:0] SEARCH_CHUNK = 16'd8;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_HOME = 2'd2
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_MOVE    = 5'b00010,
        ST_BACKOFF = 5'b00100,
        ST_SEARCH  = 5'b01000,
        ST_FINAL   = 5'b10000
    } seq_state_t;

    typedef struct packed {
        logic [15:0] step_delay;
        logic [31:0] phase_table;
        logic [15:0] backoff_steps;
        logic [15:0] search_limit;
        logic [15:0] final_steps;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] step_count;
        logic        forward;
        logic        sensor_closed;
    } req_t;

    typedef struct packed {
        logic        rejected;
        logic        home_ok;
        logic        done_res;
        logic        busy_res;
        logic [2:0]  phase;
        logic [3:0]  coil_drive;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/shhd_cfg.sv =====
// Configuration register file for the stepper sequencer.
`default_nettype none
module shhd_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [shhd_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [31:0]                    wr_data,
    output shhd_pkg::cfg_t                      cfg
);
    import shhd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_STEP_DELAY:    cfg_next.step_delay    = wr_data[15:0];
                CFG_PHASE_TABLE:   cfg_next.phase_table   = wr_data;
                CFG_BACKOFF_STEPS: cfg_next.backoff_steps = wr_data[15:0];
                CFG_SEARCH_LIMIT:  cfg_next.search_limit  = wr_data[15:0];
                CFG_FINAL_STEPS:   cfg_next.final_steps   = wr_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_delay    <= RST_STEP_DELAY;
            cfg_reg.phase_table   <= RST_PHASE_TABLE;
            cfg_reg.backoff_steps <= RST_BACKOFF_STEPS;
            cfg_reg.search_limit  <= RST_SEARCH_LIMIT;
            cfg_reg.final_steps   <= RST_FINAL_STEPS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/shhd_seq.sv =====
// Sequencer state and next-state logic for moves, homing and ticks.
`default_nettype none
module shhd_seq
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_en,
    input  wire shhd_pkg::req_t req,
    input  wire shhd_pkg::cfg_t cfg,
    output shhd_pkg::res_t      res
);
    import shhd_pkg::*;

    seq_state_t  state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] wait_reg, wait_next;
    logic [15:0] steps_reg, steps_next;
    logic [15:0] chunks_reg, chunks_next;
    logic        dir_reg, dir_next;
    logic [3:0]  coil_reg, coil_next;

    logic        busy;
    logic        do_step;
    logic        step_dir;
    logic [15:0] step_cnt;
    logic [2:0]  step_phase;
    logic        done;
    logic        ok;
    logic        rej;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        steps_next  = steps_reg;
        chunks_next = chunks_reg;
        dir_next    = dir_reg;
        coil_next   = coil_reg;
        do_step     = 1'b0;
        step_dir    = dir_reg;
        step_cnt    = steps_reg;
        done        = 1'b0;
        ok          = 1'b0;
        rej         = 1'b0;

        case (req.mode)
            MODE_TICK:
            begin
                if (busy)
                begin
                    if (wait_reg != 16'd0)
                    begin
                        wait_next = wait_reg - 16'd1;
                    end
                    else if (steps_reg != 16'd0)
                    begin
                        do_step = 1'b1;
                    end
                    else
                    begin
                        case (state_reg)
                            ST_BACKOFF:
                            begin
                                if (chunks_reg == 16'd0)
                                begin
                                    state_next = ST_IDLE;
                                    done       = 1'b1;
                                end
                                else
                                begin
                                    chunks_next = chunks_reg - 16'd1;
                                    state_next  = ST_SEARCH;
                                    step_dir    = 1'b1;
                                    step_cnt    = SEARCH_CHUNK;
                                    do_step     = 1'b1;
                                end
                            end
                            ST_SEARCH:
                            begin
                                if (req.sensor_closed)
                                begin
                                    step_dir = 1'b1;
                                    dir_next = 1'b1;
                                    if (cfg.final_steps != 16'd0)
                                    begin
                                        state_next = ST_FINAL;
                                        step_cnt   = cfg.final_steps;
                                        do_step    = 1'b1;
                                    end
                                    else
                                    begin
                                        state_next = ST_IDLE;
                                        steps_next = 16'd0;
                                        done       = 1'b1;
                                        ok         = 1'b1;
                                    end
                                end
                                else if (chunks_reg == 16'd0)
                                begin
                                    state_next = ST_IDLE;
                                    done       = 1'b1;
                                end
                                else
                                begin
                                    chunks_next = chunks_reg - 16'd1;
                                    step_dir    = 1'b1;
                                    step_cnt    = SEARCH_CHUNK;
                                    do_step     = 1'b1;
                                end
                            end
                            ST_FINAL:
                            begin
                                state_next = ST_IDLE;
                                done       = 1'b1;
                                ok         = 1'b1;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                                done       = 1'b1;
                            end
                        endcase
                    end
                end
            end
            MODE_MOVE:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    state_next = ST_MOVE;
                    steps_next = req.step_count;
                    dir_next   = req.forward;
                    wait_next  = 16'd0;
                end
            end
            MODE_HOME:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    state_next  = ST_BACKOFF;
                    steps_next  = req.sensor_closed ? cfg.backoff_steps : 16'd0;
                    dir_next    = 1'b0;
                    chunks_next = cfg.search_limit;
                    wait_next   = 16'd0;
                end
            end
            default:
            begin
                rej = 1'b0;
            end
        endcase

        step_phase = step_dir ? (phase_reg + 3'd1) : (phase_reg - 3'd1);
        if (do_step)
        begin
            dir_next   = step_dir;
            phase_next = step_phase;
            coil_next  = cfg.phase_table[{step_phase, 2'b00} +: 4];
            steps_next = step_cnt - 16'd1;
            wait_next  = cfg.step_delay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= 3'd0;
            wait_reg   <= 16'd0;
            steps_reg  <= 16'd0;
            chunks_reg <= 16'd0;
            dir_reg    <= 1'b1;
            coil_reg   <= 4'd0;
        end
        else if (req_en)
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            wait_reg   <= wait_next;
            steps_reg  <= steps_next;
            chunks_reg <= chunks_next;
            dir_reg    <= dir_next;
            coil_reg   <= coil_next;
        end
    end

    always_comb
    begin
        res.coil_drive = coil_next;
        res.phase      = phase_next;
        res.busy_res   = (state_next != ST_IDLE);
        res.done_res   = done;
        res.home_ok    = ok;
        res.rejected   = rej;
    end

endmodule
`default_nettype wire

// ===== rtl/stepper_half_step_homing_driver.sv =====
// Top level of the half-step stepper sequencer with homing and result register.
// The result of an accepted request is registered and shown on the master side in the cycle after acceptance.
// Throughput: one request per cycle while the master side takes each result; the sequencer state updates at acceptance.
// A held result does not block a new request while the master side takes it.
// Reset (rst_n low, asynchronous): sequencer idle, phase 0, coils off,
// configuration registers at their default values, no result pending.
`default_nettype none
module stepper_half_step_homing_driver
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    input  wire logic [23:0]                    s_axis_tdata,  // step_count, forward, sensor_closed
    input  wire logic [1:0]                     s_axis_tuser,  // mode
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output      logic [15:0]                    m_axis_tdata,  // coil_drive, phase, busy_res,
                                                               // done_res, home_ok, rejected
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [shhd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);
    import shhd_pkg::*;

    cfg_t cfg;
    req_t req;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;
    logic in_accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        req.mode          = mode_t'(s_axis_tuser);
        req.step_count    = s_axis_tdata[15:0];
        req.forward       = s_axis_tdata[16];
        req.sensor_closed = s_axis_tdata[17];
    end

    shhd_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    shhd_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_en (in_accept),
        .req    (req),
        .cfg    (cfg),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, res_reg};

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    a_done_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("finished sequence still busy");

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_reg.rejected) |-> (res_reg.busy_res && !res_reg.done_res))
        else $error("request rejected while idle");

    a_ok_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_reg.home_ok) |-> res_reg.done_res)
        else $error("home success without finish");

endmodule
`default_nettype wire

// ===== tb/sv/stepper_result_checker.sv =====
// Checker for the stepper sequencer: predicts every result from the requests and compares.
module stepper_result_checker
    import shhd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [23:0]          s_axis_tdata,   // step_count, forward, sensor_closed
    input  wire logic [1:0]           s_axis_tuser,   // mode
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [15:0]          m_axis_tdata,   // coil_drive, phase, busy_res,
                                                      // done_res, home_ok, rejected
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output int unsigned               err_count,
    output int unsigned               results_seen,
    output int unsigned               done_seen,
    output int unsigned               home_found,
    output int unsigned               rejects_seen,
    output int unsigned               awaiting,
    output logic                      busy_after
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        seq_state_t  st;
        logic [2:0]  ph;
        logic [15:0] wait_cnt;
        logic [15:0] steps;
        logic [15:0] chunks;
        logic        dir;
        logic [3:0]  coils;
    } motor_t;

    localparam motor_t MOTOR_RESET = '{ST_IDLE, 3'd0, 16'd0, 16'd0, 16'd0, 1'b1, 4'd0};
    localparam cfg_t   REGS_RESET  = '{RST_STEP_DELAY, RST_PHASE_TABLE, RST_BACKOFF_STEPS,
                                       RST_SEARCH_LIMIT, RST_FINAL_STEPS};

    motor_t motor;
    cfg_t   regs;
    res_t   expected_res[$];
    req_t   incoming;
    res_t   seen;

    assign incoming = {s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[16], s_axis_tdata[17]};
    assign seen     = m_axis_tdata[10:0];

    function automatic void advance_motor(inout motor_t m, input cfg_t c, input req_t r,
                                          output res_t o);
        logic stop;
        int   g;
        o    = '0;
        stop = 1'b0;
        if (r.mode == MODE_TICK) begin
            if (m.st != ST_IDLE) begin
                if (m.wait_cnt != 16'd0) begin
                    m.wait_cnt = m.wait_cnt - 16'd1;
                end
                else begin
                    for (g = 0; g < 4; g++) begin
                        if (!stop) begin
                            if (m.steps != 16'd0) begin
                                m.ph       = m.dir ? m.ph + 3'd1 : m.ph - 3'd1;
                                m.coils    = c.phase_table[{m.ph, 2'b00} +: 4];
                                m.steps    = m.steps - 16'd1;
                                m.wait_cnt = c.step_delay;
                                stop       = 1'b1;
                            end
                            else if (m.st == ST_SEARCH && r.sensor_closed) begin
                                m.st    = ST_FINAL;
                                m.steps = c.final_steps;
                                m.dir   = 1'b1;
                            end
                            else if (m.st == ST_BACKOFF || m.st == ST_SEARCH) begin
                                if (m.chunks == 16'd0) begin
                                    m.st       = ST_IDLE;
                                    o.done_res = 1'b1;
                                    stop       = 1'b1;
                                end
                                else begin
                                    m.chunks = m.chunks - 16'd1;
                                    m.steps  = SEARCH_CHUNK;
                                    m.dir    = 1'b1;
                                    m.st     = ST_SEARCH;
                                end
                            end
                            else begin
                                o.home_ok  = (m.st == ST_FINAL);
                                m.st       = ST_IDLE;
                                o.done_res = 1'b1;
                                stop       = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        else if (r.mode == MODE_MOVE || r.mode == MODE_HOME) begin
            if (m.st != ST_IDLE) begin
                o.rejected = 1'b1;
            end
            else if (r.mode == MODE_MOVE) begin
                m.st       = ST_MOVE;
                m.steps    = r.step_count;
                m.dir      = r.forward;
                m.wait_cnt = 16'd0;
            end
            else begin
                m.st       = ST_BACKOFF;
                m.steps    = r.sensor_closed ? c.backoff_steps : 16'd0;
                m.dir      = 1'b0;
                m.chunks   = c.search_limit;
                m.wait_cnt = 16'd0;
            end
        end
        o.coil_drive = m.coils;
        o.phase      = m.ph;
        o.busy_res   = (m.st != ST_IDLE);
    endfunction

    function automatic int field_check(input string name, input logic [3:0] want,
                                       input logic [3:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always_comb
    begin : lookahead
        motor_t probe;
        res_t   scratch;
        probe = motor;
        advance_motor(probe, regs, incoming, scratch);
        busy_after = (s_axis_tvalid && s_axis_tready) ? (probe.st != ST_IDLE)
                                                      : (motor.st != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin : track
        motor_t next_m;
        res_t   want;
        res_t   predicted;
        int     fails;
        if (!rst_n) begin
            motor        <= MOTOR_RESET;
            regs         <= REGS_RESET;
            expected_res.delete();
            err_count    <= 0;
            results_seen <= 0;
            done_seen    <= 0;
            home_found   <= 0;
            rejects_seen <= 0;
            awaiting     <= 0;
        end
        else begin
            fails = 0;
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen <= results_seen + 1;
                done_seen    <= done_seen + seen.done_res;
                home_found   <= home_found + seen.home_ok;
                rejects_seen <= rejects_seen + seen.rejected;
                if (expected_res.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, m_axis_tdata);
                    fails = fails + 1;
                end
                else begin
                    want  = expected_res.pop_front();
                    fails = fails + field_check("coil_drive", want.coil_drive, seen.coil_drive);
                    fails = fails + field_check("phase", {1'b0, want.phase}, {1'b0, seen.phase});
                    fails = fails + field_check("busy_res", {3'd0, want.busy_res},
                                                {3'd0, seen.busy_res});
                    fails = fails + field_check("done_res", {3'd0, want.done_res},
                                                {3'd0, seen.done_res});
                    fails = fails + field_check("home_ok", {3'd0, want.home_ok},
                                                {3'd0, seen.home_ok});
                    fails = fails + field_check("rejected", {3'd0, want.rejected},
                                                {3'd0, seen.rejected});
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STEP_DELAY:    regs.step_delay    <= cfg_data[15:0];
                    CFG_PHASE_TABLE:   regs.phase_table   <= cfg_data;
                    CFG_BACKOFF_STEPS: regs.backoff_steps <= cfg_data[15:0];
                    CFG_SEARCH_LIMIT:  regs.search_limit  <= cfg_data[15:0];
                    CFG_FINAL_STEPS:   regs.final_steps   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                next_m = motor;
                advance_motor(next_m, regs, incoming, predicted);
                expected_res.push_back(predicted);
                motor <= next_m;
            end
            err_count <= err_count + fails;
            awaiting  <= expected_res.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the stepper sequencer testbench: clock, reset, stimulus, watchdog and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import shhd_pkg::*;

    localparam logic [1:0]  MODE_NONE     = 2'd3;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_ITEMS   = 65;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;   // step_count, forward, sensor_closed
    logic [1:0]           s_axis_tuser = '0;   // mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;        // coil_drive, phase, busy_res,
                                               // done_res, home_ok, rejected
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    int unsigned err_count;
    int unsigned results_seen;
    int unsigned done_seen;
    int unsigned home_found;
    int unsigned rejects_seen;
    int unsigned awaiting;
    logic        busy_after;

    bit          steady = 1'b0;
    bit          sink_open = 1'b0;
    int unsigned stall_cycles = 0;
    int unsigned settings_used = 1;

    stepper_half_step_homing_driver dut (.*);

    stepper_result_checker checker_i (.*);

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    initial
    begin : sink
        int unsigned n;
        forever begin
            @(posedge clk);
            n = sink_open ? 0 : idle_len();
            if (n != 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] mode, input logic [15:0] count,
                             input logic fwd, input logic sensor);
        int unsigned gap;
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {6'd0, sensor, fwd, count};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic settle();
        while (busy_after)
            push_item(MODE_TICK, 16'($urandom), 1'($urandom), $urandom_range(2, 0) == 0);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaiting != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_regs(input logic [15:0] delay, input logic [31:0] pattern_tbl,
                             input logic [15:0] backoff, input logic [15:0] search,
                             input logic [15:0] final_cnt);
        write_reg(CFG_STEP_DELAY, {16'd0, delay});
        write_reg(CFG_PHASE_TABLE, pattern_tbl);
        write_reg(CFG_BACKOFF_STEPS, {16'd0, backoff});
        write_reg(CFG_SEARCH_LIMIT, {16'd0, search});
        write_reg(CFG_FINAL_STEPS, {16'd0, final_cnt});
        cfg_valid     <= 1'b0;
        settings_used  = settings_used + 1;
    endtask

    initial
    begin : stimulus
        int unsigned k;
        int unsigned r;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_item(MODE_TICK, 16'h0000, 1'b0, 1'b0);
        push_item(MODE_NONE, 16'hFFFF, 1'b1, 1'b1);
        push_item(MODE_MOVE, 16'h0000, 1'b1, 1'b0);
        push_item(MODE_TICK, 16'h0000, 1'b0, 1'b0);
        push_item(MODE_MOVE, 16'd4, 1'b0, 1'b1);
        push_item(MODE_MOVE, 16'hFFFF, 1'b1, 1'b1);
        push_item(MODE_HOME, 16'hA5A5, 1'b0, 1'b1);
        push_item(MODE_NONE, 16'h0000, 1'b0, 1'b0);
        settle();
        push_item(MODE_HOME, 16'h0000, 1'b0, 1'b0);
        settle();

        load_regs(16'd0, 32'h0000_0000, 16'd5, 16'd0, 16'd3);
        push_item(MODE_HOME, 16'h0000, 1'b0, 1'b1);
        settle();
        push_item(MODE_HOME, 16'h0000, 1'b0, 1'b0);
        settle();
        push_item(MODE_MOVE, 16'd10, 1'b1, 1'b0);
        settle();

        steady    <= 1'b1;
        sink_open <= 1'b1;
        load_regs(16'd0, 32'hFFFF_FFFF, 16'd20, 16'hFFFF, 16'd0);
        push_item(MODE_HOME, 16'h0000, 1'b1, 1'b1);
        settle();
        load_regs(16'd50, $urandom, 16'd0, 16'd2, 16'd1);
        push_item(MODE_MOVE, 16'd1, 1'b1, 1'b0);
        settle();
        sink_open <= 1'b0;

        for (k = 0; k < RANDOM_PHASES; k++) begin
            steady <= (k % 3 == 2);
            load_regs(16'($urandom_range(3, 0)), $urandom, 16'($urandom_range(12, 0)),
                      16'($urandom_range(5, 0)), 16'($urandom_range(10, 0)));
            repeat (PHASE_ITEMS) begin
                r = $urandom_range(99, 0);
                if (!busy_after) begin
                    if (r < 45)
                        push_item(MODE_MOVE,
                                  ($urandom_range(19, 0) == 0) ? 16'd0
                                                               : 16'($urandom_range(12, 1)),
                                  1'($urandom), 1'($urandom));
                    else if (r < 80)
                        push_item(MODE_HOME, 16'($urandom), 1'($urandom), 1'($urandom));
                    else if (r < 95)
                        push_item(MODE_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
                    else
                        push_item(MODE_NONE, 16'($urandom), 1'($urandom), 1'($urandom));
                end
                else begin
                    if (r < 85)
                        push_item(MODE_TICK, 16'($urandom), 1'($urandom),
                                  $urandom_range(2, 0) == 0);
                    else if (r < 95)
                        push_item(r[0] ? MODE_MOVE : MODE_HOME, 16'($urandom),
                                  1'($urandom), 1'($urandom));
                    else
                        push_item(MODE_NONE, 16'($urandom), 1'($urandom), 1'($urandom));
                end
            end
            settle();
        end

        $display("Run covered %0d requests under %0d register settings, all results checked.",
                 results_seen, settings_used);
        $display("Sequences finished: %0d, homing hits: %0d, commands refused while busy: %0d.",
                 done_seen, home_found, rejects_seen);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
